FILE: hw/rtl/teha_pkg.sv
`timescale 1ns / 1ps

package teha_pkg;

    typedef enum logic [2:0] {
        CMD_ALLOC_PERM = 3'd0,
        CMD_ALLOC_TEMP = 3'd1,
        CMD_FREE_TEMP  = 3'd2,
        CMD_SET_MARK   = 3'd3,
        CMD_CLEAR_MARK = 3'd4,
        CMD_CLEAR_ALL  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_ZERO     = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    localparam logic [1:0] PREF_LOW  = 2'd0;
    localparam logic [1:0] PREF_HIGH = 2'd1;

    localparam int unsigned TEMP_ALIGN   = 8;
    localparam int unsigned ARITH_W      = 36;
    localparam logic [31:0] REGION_RESET = 32'd268435456;

    typedef struct packed {
        status_t     status;
        logic [31:0] payload_offset;
        logic [31:0] block_bytes;
        logic [31:0] bytes_left;
        logic        permanent_on_low;
        logic        mark_present;
    } result_t;

endpackage

FILE: hw/rtl/teha_step.sv
`timescale 1ns / 1ps

module teha_step
    import teha_pkg::*;
#(
    parameter int unsigned REGION_BITS  = 32,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned LINE_ALIGN   = 64
) (
    input  cmd_t                   cmd_i,
    input  logic [31:0]            req_i,
    input  logic [1:0]             pref_i,
    input  logic [31:0]            foff_i,
    input  logic [31:0]            fbytes_i,
    input  logic [REGION_BITS-1:0] region_i,
    input  logic                   pel_i,
    input  logic [REGION_BITS-1:0] perm_i [2],
    input  logic [REGION_BITS-1:0] temp_i [2],
    input  logic [REGION_BITS-1:0] mark_i [2],
    input  logic [REGION_BITS-1:0] hw_i   [2],
    output logic                   pel_o,
    output logic [REGION_BITS-1:0] perm_o [2],
    output logic [REGION_BITS-1:0] temp_o [2],
    output logic [REGION_BITS-1:0] mark_o [2],
    output logic [REGION_BITS-1:0] hw_o   [2],
    output result_t                res_o
);

    localparam int unsigned RB = REGION_BITS;
    localparam int unsigned AW = ARITH_W;

    logic                 t0;
    logic                 t_empty;
    logic signed [RB+1:0] dt;
    logic signed [RB+1:0] dp;
    logic                 swap_ok;
    logic                 call;
    logic                 pel_n;
    logic                 pn;
    logic                 tn;
    logic [AW-1:0]        hdr;
    logic [AW-1:0]        region_w;
    logic [AW-1:0]        req_w;
    logic [AW-1:0]        blk_p;
    logic [AW-1:0]        blk_t;
    logic [AW-1:0]        new_top;
    logic [AW-1:0]        diff;
    logic                 free_ok;
    logic [RB-1:0]        lo;
    logic [RB-1:0]        hi;
    logic [AW-1:0]        used;

    always_comb begin
        perm_o  = perm_i;
        temp_o  = temp_i;
        mark_o  = mark_i;
        hw_o    = hw_i;
        pel_o   = pel_i;
        res_o   = '0;
        call    = 1'b0;
        pel_n   = pel_i;
        pn      = ~pel_i;
        tn      = pel_i;
        new_top = '0;
        free_ok = 1'b0;

        hdr      = AW'(HEADER_BYTES);
        region_w = AW'(region_i);
        req_w    = AW'(req_i);
        blk_p    = hdr + ((req_w + AW'(LINE_ALIGN - 1)) & ~AW'(LINE_ALIGN - 1));
        blk_t    = hdr + ((req_w + AW'(TEMP_ALIGN - 1)) & ~AW'(TEMP_ALIGN - 1));

        t0      = pel_i;
        t_empty = (temp_i[t0] == perm_i[t0]);
        dt      = $signed({2'b00, hw_i[t0]}) - $signed({2'b00, perm_i[t0]});
        dp      = $signed({2'b00, hw_i[~t0]}) - $signed({2'b00, perm_i[~t0]});
        swap_ok = t_empty && (dt > dp);
        diff    = AW'(temp_i[t0]) - AW'(perm_i[t0]);

        case (cmd_i)
            CMD_ALLOC_PERM: begin
                if (req_i == 32'd0) begin
                    res_o.status = ST_ZERO;
                end else begin
                    call = (pref_i != PREF_LOW && pref_i != PREF_HIGH) || !t_empty
                        || (pref_i == PREF_LOW && !pel_i) || (pref_i == PREF_HIGH && pel_i);
                    pel_n = pel_i ^ (call && swap_ok);
                    pel_o = pel_n;
                    pn    = ~pel_n;
                    res_o.block_bytes = blk_p[31:0];
                    new_top = AW'(perm_i[pn]) + blk_p;
                    if (AW'(temp_i[0]) + AW'(temp_i[1]) + blk_p > region_w) begin
                        res_o.status = ST_NO_ROOM;
                    end else begin
                        perm_o[pn] = RB'(new_top);
                        temp_o[pn] = RB'(new_top);
                        if (pel_n) begin
                            res_o.payload_offset = 32'(AW'(perm_i[pn]) + hdr);
                        end else begin
                            res_o.payload_offset = 32'(region_w - new_top + hdr);
                        end
                    end
                end
            end
            CMD_ALLOC_TEMP: begin
                pel_n = pel_i ^ swap_ok;
                pel_o = pel_n;
                pn    = ~pel_n;
                tn    = pel_n;
                res_o.block_bytes = blk_t[31:0];
                new_top = AW'(temp_i[tn]) + blk_t;
                if (AW'(temp_i[tn]) + AW'(perm_i[pn]) + blk_t > region_w) begin
                    res_o.status = ST_NO_ROOM;
                end else begin
                    temp_o[tn] = RB'(new_top);
                    if (pel_n) begin
                        res_o.payload_offset = 32'(region_w - new_top + hdr);
                    end else begin
                        res_o.payload_offset = 32'(AW'(temp_i[tn]) + hdr);
                    end
                    if (RB'(new_top) > hw_i[tn]) begin
                        hw_o[tn] = RB'(new_top);
                    end
                end
            end
            CMD_FREE_TEMP: begin
                if (AW'(fbytes_i) <= diff) begin
                    if (!pel_i) begin
                        free_ok = (AW'(foff_i) == AW'(temp_i[t0]) - AW'(fbytes_i) + hdr);
                    end else if (temp_i[t0] <= region_i) begin
                        free_ok = (AW'(foff_i) == region_w - AW'(temp_i[t0]) + hdr);
                    end
                end
                if (free_ok) begin
                    temp_o[t0] = RB'(AW'(temp_i[t0]) - AW'(fbytes_i));
                end else begin
                    res_o.status = ST_IGNORED;
                end
            end
            CMD_SET_MARK: begin
                mark_o = perm_i;
            end
            CMD_CLEAR_MARK: begin
                perm_o = mark_i;
                temp_o = mark_i;
            end
            CMD_CLEAR_ALL: begin
                perm_o = '{default: '0};
                temp_o = '{default: '0};
                mark_o = '{default: '0};
                hw_o   = '{default: '0};
                pel_o  = 1'b1;
            end
            default: begin
            end
        endcase

        lo   = (perm_o[0] > temp_o[0]) ? perm_o[0] : temp_o[0];
        hi   = (perm_o[1] > temp_o[1]) ? perm_o[1] : temp_o[1];
        used = AW'(lo) + AW'(hi);
        res_o.bytes_left       = (used >= region_w) ? 32'd0 : 32'(region_w - used);
        res_o.permanent_on_low = pel_o;
        res_o.mark_present     = (mark_o[0] != '0) || (mark_o[1] != '0);
    end

endmodule

FILE: hw/rtl/two_ended_hunk_allocator.sv
// Two-ended stack allocator over one region of memory offsets.
// Commands arrive on the s_ stream: s_tuser carries the command, s_tdata
// its operands. Each command gives exactly one result on the m_ stream:
// m_tuser carries the status, m_tdata the offset, block size, space left
// and the end and mark flags.
// The region size is written on the cfg_ channel; the user must write it
// only while no command is in flight, as the block does not enforce this.
// cfg_ready is always high. Each command lands in the input register and
// its result loads into the output register once that register is free.
// One command per cycle while results are taken. The state registers feed
// the next command straight from the single combinational step.
// Reset clears both ends, puts permanent blocks on the low end and sets
// the region to 256 MiB. When the receiver stalls, the result holds in
// the output register, one more command waits in the input register, and
// s_tready drops until the result is transferred.
`timescale 1ns / 1ps

module two_ended_hunk_allocator
    import teha_pkg::*;
#(
    parameter int unsigned SPACE_BITS   = 32,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned LINE_ALIGN   = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_bytes[31:0], end_pref[33:32], free_offset[65:34], free_bytes[97:66]
    input  logic [103:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // payload_offset[31:0], block_bytes[63:32], bytes_left[95:64],
    // permanent_on_low[96], mark_present[97]
    output logic [103:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned RB = (SPACE_BITS < 32) ? SPACE_BITS : 32;

    logic          in_valid_reg;
    cmd_t          cmd_reg;
    logic [31:0]   req_reg;
    logic [1:0]    pref_reg;
    logic [31:0]   foff_reg;
    logic [31:0]   fbytes_reg;
    logic [RB-1:0] region_reg;
    logic          pel_reg;
    logic          pel_next;
    logic [RB-1:0] perm_reg [2];
    logic [RB-1:0] temp_reg [2];
    logic [RB-1:0] mark_reg [2];
    logic [RB-1:0] hw_reg   [2];
    logic [RB-1:0] perm_next [2];
    logic [RB-1:0] temp_next [2];
    logic [RB-1:0] mark_next [2];
    logic [RB-1:0] hw_next   [2];
    logic          m_valid_reg;
    result_t       res_reg;
    result_t       res_next;
    logic          advance;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = res_reg.status;
    assign m_tdata   = {6'd0, res_reg.mark_present, res_reg.permanent_on_low,
                        res_reg.bytes_left, res_reg.block_bytes, res_reg.payload_offset};

    teha_step #(
        .REGION_BITS (RB),
        .HEADER_BYTES(HEADER_BYTES),
        .LINE_ALIGN  (LINE_ALIGN)
    ) u_step (
        .cmd_i   (cmd_reg),
        .req_i   (req_reg),
        .pref_i  (pref_reg),
        .foff_i  (foff_reg),
        .fbytes_i(fbytes_reg),
        .region_i(region_reg),
        .pel_i   (pel_reg),
        .perm_i  (perm_reg),
        .temp_i  (temp_reg),
        .mark_i  (mark_reg),
        .hw_i    (hw_reg),
        .pel_o   (pel_next),
        .perm_o  (perm_next),
        .temp_o  (temp_next),
        .mark_o  (mark_next),
        .hw_o    (hw_next),
        .res_o   (res_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg    <= cmd_t'(s_tuser);
            req_reg    <= s_tdata[31:0];
            pref_reg   <= s_tdata[33:32];
            foff_reg   <= s_tdata[65:34];
            fbytes_reg <= s_tdata[97:66];
        end
    end

    // allocator state and region size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg <= RB'(REGION_RESET);
            pel_reg    <= 1'b1;
            perm_reg   <= '{default: '0};
            temp_reg   <= '{default: '0};
            mark_reg   <= '{default: '0};
            hw_reg     <= '{default: '0};
        end else begin
            if (cfg_valid && cfg_ready) begin
                region_reg <= cfg_data[RB-1:0];
            end
            if (advance) begin
                pel_reg  <= pel_next;
                perm_reg <= perm_next;
                temp_reg <= temp_next;
                mark_reg <= mark_next;
                hw_reg   <= hw_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_perm_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (pel_reg ? (temp_reg[0] == perm_reg[0]) : (temp_reg[1] == perm_reg[1])))
        else $error("permanent end holds temporary blocks");

    a_temp_end_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (pel_reg ? (temp_reg[1] >= perm_reg[1]) : (temp_reg[0] >= perm_reg[0])))
        else $error("temporary top below permanent top");

    a_fail_no_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.status != ST_OK) |-> (res_reg.payload_offset == 32'd0))
        else $error("failed command returned an offset");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("transfer lost at input register");
`endif

endmodule

FILE: sim/two_ended_hunk_allocator_checker.sv
`timescale 1ns / 1ps

module two_ended_hunk_allocator_checker
    import teha_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned LINE_ALIGN   = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // req_bytes[31:0], end_pref[33:32], free_offset[65:34], free_bytes[97:66]
    input  logic [103:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // payload_offset[31:0], block_bytes[63:32], bytes_left[95:64],
    // permanent_on_low[96], mark_present[97]
    input  logic [103:0] m_tdata,
    // status[1:0]
    input  logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    output int           errors,
    output int           outstanding,
    output logic         temp_on_low,
    output logic [63:0]  temp_top,
    output logic [63:0]  temp_span,
    output logic [31:0]  region
);

    typedef struct packed {
        logic [63:0] perm;
        logic [63:0] temp;
        logic [63:0] mark;
        logic [63:0] hw;
    } stack_end_t;

    stack_end_t  stack_end [2];
    logic        perm_on_low;
    logic [63:0] region_size;
    result_t     expected_q [$];
    int          mismatches = 0;

    function automatic logic [63:0] round_up(input logic [63:0] x, input logic [63:0] a);
        return ((x + a - 64'd1) / a) * a;
    endfunction

    function automatic void clear_ends();
        for (int i = 0; i < 2; i++)
            stack_end[i] = '0;
        perm_on_low = 1'b1;
    endfunction

    // swap roles only when the temp end is empty and its high water leads
    function automatic void maybe_swap_ends();
        int    p;
        int    t;
        longint dt;
        longint dp;
        p = perm_on_low ? 0 : 1;
        t = perm_on_low ? 1 : 0;
        if (stack_end[t].temp != stack_end[t].perm)
            return;
        dt = longint'(stack_end[t].hw) - longint'(stack_end[t].perm);
        dp = longint'(stack_end[p].hw) - longint'(stack_end[p].perm);
        if (dt > dp)
            perm_on_low = ~perm_on_low;
    endfunction

    function automatic result_t predict_hunk(input logic [2:0] op, input logic [31:0] req,
                                             input logic [1:0] pref, input logic [31:0] foff,
                                             input logic [31:0] fbytes);
        result_t     r;
        logic [63:0] blk;
        logic [63:0] pay;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] used;
        logic [63:0] left;
        logic        ok;
        int          p;
        int          t;
        r   = '0;
        blk = '0;
        pay = '0;
        r.status = ST_OK;
        case (op)
            CMD_ALLOC_PERM: begin
                if (req == 32'd0) begin
                    r.status = ST_ZERO;
                end else begin
                    t = perm_on_low ? 1 : 0;
                    if (pref[1] || stack_end[t].temp != stack_end[t].perm)
                        maybe_swap_ends();
                    else if (pref == PREF_LOW && !perm_on_low)
                        maybe_swap_ends();
                    else if (pref == PREF_HIGH && perm_on_low)
                        maybe_swap_ends();
                    blk = HEADER_BYTES + round_up(req, LINE_ALIGN);
                    p = perm_on_low ? 0 : 1;
                    if (stack_end[0].temp + stack_end[1].temp + blk > region_size) begin
                        r.status = ST_NO_ROOM;
                    end else if (perm_on_low) begin
                        pay = stack_end[p].perm + HEADER_BYTES;
                        stack_end[p].perm = stack_end[p].perm + blk;
                        stack_end[p].temp = stack_end[p].perm;
                    end else begin
                        stack_end[p].perm = stack_end[p].perm + blk;
                        stack_end[p].temp = stack_end[p].perm;
                        pay = region_size - stack_end[p].perm + HEADER_BYTES;
                    end
                end
            end
            CMD_ALLOC_TEMP: begin
                maybe_swap_ends();
                blk = HEADER_BYTES + round_up(req, TEMP_ALIGN);
                p = perm_on_low ? 0 : 1;
                t = perm_on_low ? 1 : 0;
                if (stack_end[t].temp + stack_end[p].perm + blk > region_size) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    if (!perm_on_low) begin
                        pay = stack_end[t].temp + HEADER_BYTES;
                        stack_end[t].temp = stack_end[t].temp + blk;
                    end else begin
                        stack_end[t].temp = stack_end[t].temp + blk;
                        pay = region_size - stack_end[t].temp + HEADER_BYTES;
                    end
                    if (stack_end[t].temp > stack_end[t].hw)
                        stack_end[t].hw = stack_end[t].temp;
                end
            end
            CMD_FREE_TEMP: begin
                ok = 1'b0;
                t = perm_on_low ? 1 : 0;
                if ({32'd0, fbytes} <= stack_end[t].temp - stack_end[t].perm) begin
                    if (!perm_on_low)
                        ok = ({32'd0, foff} == stack_end[t].temp - fbytes + HEADER_BYTES);
                    else if (stack_end[t].temp <= region_size)
                        ok = ({32'd0, foff} == region_size - stack_end[t].temp + HEADER_BYTES);
                end
                if (ok)
                    stack_end[t].temp = stack_end[t].temp - fbytes;
                else
                    r.status = ST_IGNORED;
            end
            CMD_SET_MARK: begin
                for (int i = 0; i < 2; i++)
                    stack_end[i].mark = stack_end[i].perm;
            end
            CMD_CLEAR_MARK: begin
                for (int i = 0; i < 2; i++) begin
                    stack_end[i].perm = stack_end[i].mark;
                    stack_end[i].temp = stack_end[i].mark;
                end
            end
            CMD_CLEAR_ALL: begin
                clear_ends();
            end
            default: begin
            end
        endcase

        lo   = stack_end[0].perm > stack_end[0].temp ? stack_end[0].perm : stack_end[0].temp;
        hi   = stack_end[1].perm > stack_end[1].temp ? stack_end[1].perm : stack_end[1].temp;
        used = lo + hi;
        left = (used >= region_size) ? 64'd0 : region_size - used;

        r.payload_offset   = pay[31:0];
        r.block_bytes      = blk[31:0];
        r.bytes_left       = left[31:0];
        r.permanent_on_low = perm_on_low;
        r.mark_present     = (stack_end[0].mark != 0) || (stack_end[1].mark != 0);
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            clear_ends();
            region_size = {32'd0, REGION_RESET};
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result transfer with nothing outstanding", $time);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", {30'd0, want.status}, {30'd0, m_tuser});
                    check_field("payload_offset", want.payload_offset, m_tdata[31:0]);
                    check_field("block_bytes", want.block_bytes, m_tdata[63:32]);
                    check_field("bytes_left", want.bytes_left, m_tdata[95:64]);
                    check_field("permanent_on_low", {31'd0, want.permanent_on_low},
                                {31'd0, m_tdata[96]});
                    check_field("mark_present", {31'd0, want.mark_present},
                                {31'd0, m_tdata[97]});
                end
            end
            if (cfg_valid && cfg_ready)
                region_size = {32'd0, cfg_data};
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_hunk(s_tuser, s_tdata[31:0], s_tdata[33:32],
                                                  s_tdata[65:34], s_tdata[97:66]));
        end
        outstanding <= expected_q.size();
        errors      <= mismatches;
        temp_on_low <= !perm_on_low;
        temp_top    <= stack_end[perm_on_low].temp;
        temp_span   <= stack_end[perm_on_low].temp - stack_end[perm_on_low].perm;
        region      <= region_size[31:0];
    end

endmodule

FILE: sim/two_ended_hunk_allocator_tb.sv
`timescale 1ns / 1ps

module two_ended_hunk_allocator_tb;
    import teha_pkg::*;

    localparam logic [31:0] HDR        = 32'd32;
    localparam logic [2:0]  CMD_RSVD_6 = 3'd6;
    localparam logic [2:0]  CMD_RSVD_7 = 3'd7;
    localparam logic [1:0]  PREF_ANY   = 2'd2;
    localparam logic [1:0]  PREF_RSVD  = 2'd3;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // req_bytes[31:0], end_pref[33:32], free_offset[65:34], free_bytes[97:66]
    logic [103:0] s_tdata;
    // cmd[2:0]
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // payload_offset[31:0], block_bytes[63:32], bytes_left[95:64],
    // permanent_on_low[96], mark_present[97]
    logic [103:0] m_tdata;
    // status[1:0]
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    int           errors;
    int           outstanding;
    logic         temp_on_low;
    logic [63:0]  temp_top;
    logic [63:0]  temp_span;
    logic [31:0]  region;
    bit           src_idle;
    bit           sink_idle;

    two_ended_hunk_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    two_ended_hunk_allocator_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .temp_on_low (temp_on_low),
        .temp_top    (temp_top),
        .temp_span   (temp_span),
        .region      (region)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        int unsigned hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 99) < 25) begin
                hold = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_req();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2, 3:    return $urandom_range(1, 4096);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [31:0] req, input logic [1:0] pref,
                            input logic [31:0] foff, input logic [31:0] fbytes);
        if (src_idle && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, fbytes, foff, pref, req};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drain, then pop the whole temp stack or a part of it from the top
    task automatic free_top(input bit whole);
        logic [31:0] nbytes;
        logic [31:0] off;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        if (whole)
            nbytes = temp_span[31:0];
        else
            nbytes = $urandom_range(0, temp_span[31:3]) * 8;
        if (temp_on_low)
            off = temp_top[31:0] - nbytes + HDR;
        else
            off = region - temp_top[31:0] + HDR;
        send_cmd(CMD_FREE_TEMP, $urandom, PREF_ANY, off, nbytes);
    endtask

    task automatic set_region(input logic [31:0] bytes);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= bytes;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int unsigned roll;
        logic [2:0]  op;
        logic [1:0]  pref;
        roll = $urandom_range(0, 99);
        pref = 2'($urandom_range(0, 3));
        if (roll < 12 && (src_idle || sink_idle)) begin
            free_top(1'($urandom_range(0, 1)));
        end else begin
            if (roll < 15)
                op = CMD_FREE_TEMP;
            else if (roll < 45)
                op = CMD_ALLOC_PERM;
            else if (roll < 75)
                op = CMD_ALLOC_TEMP;
            else if (roll < 83)
                op = CMD_SET_MARK;
            else if (roll < 90)
                op = CMD_CLEAR_MARK;
            else if (roll < 94)
                op = CMD_CLEAR_ALL;
            else
                op = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
            send_cmd(op, pick_req(), pref, $urandom, $urandom);
        end
    endtask

    task automatic run_random(input int count, input bit calm);
        for (int i = 0; i < count; i++) begin
            if (calm) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else if (i % 40 == 0) begin
                src_idle  = $urandom_range(0, 9) < 7;
                sink_idle = $urandom_range(0, 9) < 7;
            end
            random_item();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_cmd(CMD_ALLOC_PERM, 32'd1, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_PERM, 32'd0, PREF_ANY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC_PERM, 32'd64, PREF_RSVD, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd1, PREF_HIGH, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd13, PREF_ANY, 32'd0, 32'd0);
        send_cmd(CMD_FREE_TEMP, 32'd0, PREF_LOW, 32'd0, 32'd56);
        send_cmd(CMD_FREE_TEMP, 32'd0, PREF_LOW, 32'd0, 32'hFFFF_FFFF);
        free_top(1'b1);
        send_cmd(CMD_ALLOC_PERM, 32'd100, PREF_HIGH, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd8, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_SET_MARK, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_PERM, 32'd4096, PREF_ANY, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd4095, PREF_ANY, 32'd0, 32'd0);
        free_top(1'b0);
        send_cmd(CMD_CLEAR_MARK, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_RSVD_6, 32'hFFFF_FFFF, PREF_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_RSVD_7, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_CLEAR_ALL, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_PERM, 32'hFFFF_FFFF, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'hFFFF_FFFF, PREF_LOW, 32'd0, 32'd0);

        set_region(32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd0, PREF_LOW, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_PERM, 32'd1, PREF_HIGH, 32'd0, 32'd0);

        set_region(32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC_PERM, 32'hFFFF_FFC0, PREF_ANY, 32'd0, 32'd0);
        send_cmd(CMD_ALLOC_TEMP, 32'd0, PREF_ANY, 32'd0, 32'd0);
        send_cmd(CMD_CLEAR_ALL, 32'd0, PREF_LOW, 32'd0, 32'd0);

        set_region(32'd4096);
        run_random(150, 1'b0);
        set_region(32'd1 << 20);
        run_random(150, 1'b0);
        // shrink below the space in use
        set_region(32'd300);
        run_random(20, 1'b0);
        set_region(32'd2048);
        send_cmd(CMD_CLEAR_ALL, 32'd0, PREF_LOW, 32'd0, 32'd0);
        run_random(150, 1'b0);
        set_region(32'hFFFF_FFFF);
        run_random(100, 1'b0);
        run_random(80, 1'b1);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (8) @(posedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
